FILE: design/rmq_pkg.sv
// Shared types, constants and helpers for the rotation matrix to quaternion block.
// Used by rmq_front, rmq_div and rotation_matrix_to_quaternion.
package rmq_pkg;

  // Field and internal widths that follow from the 24-bit payload
  localparam int unsigned FieldW = 24;
  localparam int unsigned NumW   = 25;  // sum or difference of two entries
  localparam int unsigned RadW   = 26;  // positive radicand, in LSBs
  localparam int unsigned AccW   = 27;  // signed three-term accumulator
  localparam int unsigned QuoW   = 24;  // quotient bits before saturation

  localparam logic signed [FieldW-1:0] SatMax = 24'sh7FFFFF;
  localparam logic signed [FieldW-1:0] SatMin = 24'sh800000;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_W = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [FieldW-1:0] m00;
    logic signed [FieldW-1:0] m01;
    logic signed [FieldW-1:0] m02;
    logic signed [FieldW-1:0] m10;
    logic signed [FieldW-1:0] m11;
    logic signed [FieldW-1:0] m12;
    logic signed [FieldW-1:0] m20;
    logic signed [FieldW-1:0] m21;
    logic signed [FieldW-1:0] m22;
  } item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] quat_x;
    logic signed [FieldW-1:0] quat_y;
    logic signed [FieldW-1:0] quat_z;
    logic signed [FieldW-1:0] quat_w;
    logic                     degenerate;
  } result_t;

  // Control carried alongside the square root
  typedef struct packed {
    logic                   degenerate;
    axis_e                  main_axis;
    logic signed [NumW-1:0] num0;
    logic signed [NumW-1:0] num1;
    logic signed [NumW-1:0] num2;
  } ctl_t;

  // Control carried alongside divider lane 0
  typedef struct packed {
    logic                     degenerate;
    axis_e                    main_axis;
    logic signed [FieldW-1:0] main_val;
    logic                     neg;
  } lane_sb_t;

  function automatic logic [FieldW-1:0] mag24(input logic signed [FieldW-1:0] a);
    logic [FieldW-1:0] r;
    r = a[FieldW-1] ? (~a + 1'b1) : a;
    return r;
  endfunction

  function automatic logic [NumW-1:0] mag25(input logic signed [NumW-1:0] a);
    logic [NumW-1:0] r;
    r = a[NumW-1] ? (~a + 1'b1) : a;
    return r;
  endfunction

  function automatic logic signed [AccW-1:0] sx27(input logic signed [FieldW-1:0] a);
    logic signed [AccW-1:0] r;
    r = {{(AccW-FieldW){a[FieldW-1]}}, a};
    return r;
  endfunction

  function automatic logic signed [NumW-1:0] sx25(input logic signed [FieldW-1:0] a);
    logic signed [NumW-1:0] r;
    r = {a[FieldW-1], a};
    return r;
  endfunction

  // Sign and saturate one quotient lane
  function automatic logic signed [FieldW-1:0] lane_val(input logic [QuoW-1:0] quo,
                                                        input logic ovf,
                                                        input logic neg);
    logic signed [FieldW-1:0] r;
    if (ovf || quo[QuoW-1]) begin
      r = neg ? SatMin : SatMax;
    end else begin
      r = neg ? -$signed(quo) : $signed(quo);
    end
    return r;
  endfunction

endpackage

FILE: design/rmq_front.sv
// Front end: near-zero row check, trace, branch pick, radicand and numerators.
// Depends on rmq_pkg.
module rmq_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  rmq_pkg::item_t               item_i,
  input  logic [15:0]                  tol_i,
  output logic                         valid_o,
  output logic [rmq_pkg::RadW-1:0]     rad_o,
  output rmq_pkg::ctl_t                ctl_o
);

  localparam int unsigned AccW = rmq_pkg::AccW;
  localparam logic signed [AccW-1:0] One = AccW'(64'd1 << FRAC_BITS);

  // Stage B registers
  logic                   vb_q;
  rmq_pkg::item_t         mb_q;
  logic                   degb_q;
  logic                   trpos_q;
  logic [rmq_pkg::RadW-1:0] trrad_q;
  rmq_pkg::axis_e         axis_q;

  logic                   deg_d;
  logic                   trpos_d;
  logic signed [AccW-1:0] tr_d;
  logic signed [AccW-1:0] trone_d;
  rmq_pkg::axis_e         axis_d;
  logic signed [rmq_pkg::FieldW-1:0] dmax_d;

  function automatic logic row_zero(input logic signed [23:0] a, input logic signed [23:0] b,
                                    input logic signed [23:0] c, input logic [15:0] t);
    logic [23:0] tw;
    tw = {8'd0, t};
    return (rmq_pkg::mag24(a) <= tw) && (rmq_pkg::mag24(b) <= tw) &&
           (rmq_pkg::mag24(c) <= tw);
  endfunction

  // Check rows, sum the trace, pick the largest diagonal entry
  always_comb begin
    deg_d = row_zero(item_i.m00, item_i.m01, item_i.m02, tol_i) ||
            row_zero(item_i.m10, item_i.m11, item_i.m12, tol_i) ||
            row_zero(item_i.m20, item_i.m21, item_i.m22, tol_i);
    tr_d = rmq_pkg::sx27(item_i.m00) + rmq_pkg::sx27(item_i.m11) +
           rmq_pkg::sx27(item_i.m22);
    trpos_d = !tr_d[AccW-1] && (tr_d != '0);
    trone_d = tr_d + One;
    axis_d = rmq_pkg::AXIS_X;
    dmax_d = item_i.m00;
    if (item_i.m11 > item_i.m00) begin
      axis_d = rmq_pkg::AXIS_Y;
      dmax_d = item_i.m11;
    end
    if (item_i.m22 > dmax_d) begin
      axis_d = rmq_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mb_q    <= item_i;
    degb_q  <= deg_d;
    trpos_q <= trpos_d;
    trrad_q <= trone_d[rmq_pkg::RadW-1:0];
    axis_q  <= axis_d;
  end

  // Stage C: radicand and the three numerators of the chosen branch
  logic signed [AccW-1:0]          a_d;
  logic [rmq_pkg::RadW-1:0]        rad_d;
  rmq_pkg::ctl_t                   ctl_d;
  logic                            vc_q;
  logic [rmq_pkg::RadW-1:0]        rad_q;
  rmq_pkg::ctl_t                   ctl_q;

  always_comb begin
    ctl_d.degenerate = degb_q;
    ctl_d.main_axis  = axis_q;
    case (axis_q)
      rmq_pkg::AXIS_Y: begin
        a_d = rmq_pkg::sx27(mb_q.m11) - rmq_pkg::sx27(mb_q.m22) -
              rmq_pkg::sx27(mb_q.m00) + One;
        ctl_d.num0 = rmq_pkg::sx25(mb_q.m20) - rmq_pkg::sx25(mb_q.m02);
        ctl_d.num1 = rmq_pkg::sx25(mb_q.m12) + rmq_pkg::sx25(mb_q.m21);
        ctl_d.num2 = rmq_pkg::sx25(mb_q.m10) + rmq_pkg::sx25(mb_q.m01);
      end
      rmq_pkg::AXIS_Z: begin
        a_d = rmq_pkg::sx27(mb_q.m22) - rmq_pkg::sx27(mb_q.m00) -
              rmq_pkg::sx27(mb_q.m11) + One;
        ctl_d.num0 = rmq_pkg::sx25(mb_q.m01) - rmq_pkg::sx25(mb_q.m10);
        ctl_d.num1 = rmq_pkg::sx25(mb_q.m20) + rmq_pkg::sx25(mb_q.m02);
        ctl_d.num2 = rmq_pkg::sx25(mb_q.m21) + rmq_pkg::sx25(mb_q.m12);
      end
      default: begin
        a_d = rmq_pkg::sx27(mb_q.m00) - rmq_pkg::sx27(mb_q.m11) -
              rmq_pkg::sx27(mb_q.m22) + One;
        ctl_d.num0 = rmq_pkg::sx25(mb_q.m12) - rmq_pkg::sx25(mb_q.m21);
        ctl_d.num1 = rmq_pkg::sx25(mb_q.m01) + rmq_pkg::sx25(mb_q.m10);
        ctl_d.num2 = rmq_pkg::sx25(mb_q.m02) + rmq_pkg::sx25(mb_q.m20);
      end
    endcase
    // clamp a nonpositive radicand to one LSB
    if (a_d < AccW'(1)) begin
      a_d = AccW'(1);
    end
    rad_d = a_d[rmq_pkg::RadW-1:0];
    if (trpos_q) begin
      rad_d            = trrad_q;
      ctl_d.main_axis  = rmq_pkg::AXIS_W;
      ctl_d.num0 = rmq_pkg::sx25(mb_q.m12) - rmq_pkg::sx25(mb_q.m21);
      ctl_d.num1 = rmq_pkg::sx25(mb_q.m20) - rmq_pkg::sx25(mb_q.m02);
      ctl_d.num2 = rmq_pkg::sx25(mb_q.m01) - rmq_pkg::sx25(mb_q.m10);
    end
    if (degb_q) begin
      rad_d           = rmq_pkg::RadW'(1);
      ctl_d.main_axis = rmq_pkg::AXIS_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    ctl_q <= ctl_d;
  end

  assign valid_o = vc_q;
  assign rad_o   = rad_q;
  assign ctl_o   = ctl_q;

endmodule

FILE: design/rmq_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
// Carries a sideband vector in step with the data. No package dependency.
module rmq_sqrt #(
  parameter int unsigned IN_W = 42,
  parameter int unsigned SB_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [IN_W-1:0]          rad_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     valid_o,
  output logic [(IN_W+1)/2-1:0]    root_o,
  output logic [SB_W-1:0]          sb_o
);

  localparam int unsigned RootW = (IN_W + 1) / 2;
  localparam int unsigned XW    = 2 * RootW;

  logic               vld_q  [RootW];
  logic [XW-1:0]      x_q    [RootW];
  logic [RootW+1:0]   rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [SB_W-1:0]    sb_q   [RootW];

  logic               v_in    [RootW];
  logic [XW-1:0]      x_in    [RootW];
  logic [RootW+1:0]   rem_in  [RootW];
  logic [RootW-1:0]   root_in [RootW];
  logic [SB_W-1:0]    sb_in   [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_step
    logic [RootW+1:0] rem_sh;
    logic [RootW+1:0] trial;
    logic [RootW+1:0] rem_nx;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in[s]    = valid_i;
      assign x_in[s]    = XW'(rad_i);
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
      assign sb_in[s]   = sb_i;
    end else begin : g_next
      assign v_in[s]    = vld_q[s-1];
      assign x_in[s]    = x_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
      assign sb_in[s]   = sb_q[s-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[s][RootW-1:0], x_in[s][XW-1 -: 2]};
    assign trial  = {root_in[s], 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s]    <= x_in[s] << 2;
      rem_q[s]  <= rem_nx;
      root_q[s] <= {root_in[s][RootW-2:0], ge};
      sb_q[s]   <= sb_in[s];
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign sb_o    = sb_q[RootW-1];

endmodule

FILE: design/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on rmq_pkg for the quotient width.
module rmq_div #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 22,
  parameter int unsigned SB_W  = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [SB_W-1:0]             sb_i,
  output logic                        valid_o,
  output logic [rmq_pkg::QuoW-1:0]    quo_o,
  output logic                        ovf_o,
  output logic [SB_W-1:0]             sb_o
);

  localparam int unsigned QuoW = rmq_pkg::QuoW;
  localparam int unsigned HiW  = NUM_W - QuoW;
  localparam int unsigned CmpW = (HiW > DEN_W) ? HiW : DEN_W;

  // Entry stage: the quotient fits in QuoW bits only if num >> QuoW < den
  logic [CmpW-1:0]  hi_d;
  logic             v0_q;
  logic             ovf0_q;
  logic [DEN_W-1:0] rem0_q;
  logic [QuoW-1:0]  n0_q;
  logic [DEN_W-1:0] d0_q;
  logic [SB_W-1:0]  sb0_q;

  assign hi_d = CmpW'(num_i[NUM_W-1:QuoW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf0_q <= hi_d >= CmpW'(den_i);
    rem0_q <= hi_d[DEN_W-1:0];
    n0_q   <= num_i[QuoW-1:0];
    d0_q   <= den_i;
    sb0_q  <= sb_i;
  end

  logic             vld_q [QuoW];
  logic             ovf_q [QuoW];
  logic [DEN_W-1:0] rem_q [QuoW];
  logic [QuoW-1:0]  n_q   [QuoW];
  logic [QuoW-1:0]  q_q   [QuoW];
  logic [DEN_W-1:0] d_q   [QuoW];
  logic [SB_W-1:0]  sb_q  [QuoW];

  logic             v_in   [QuoW];
  logic             ovf_in [QuoW];
  logic [DEN_W-1:0] rem_in [QuoW];
  logic [QuoW-1:0]  n_in   [QuoW];
  logic [QuoW-1:0]  q_in   [QuoW];
  logic [DEN_W-1:0] d_in   [QuoW];
  logic [SB_W-1:0]  sb_in  [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_step
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    if (s == 0) begin : g_first
      assign v_in[s]   = v0_q;
      assign ovf_in[s] = ovf0_q;
      assign rem_in[s] = rem0_q;
      assign n_in[s]   = n0_q;
      assign q_in[s]   = '0;
      assign d_in[s]   = d0_q;
      assign sb_in[s]  = sb0_q;
    end else begin : g_next
      assign v_in[s]   = vld_q[s-1];
      assign ovf_in[s] = ovf_q[s-1];
      assign rem_in[s] = rem_q[s-1];
      assign n_in[s]   = n_q[s-1];
      assign q_in[s]   = q_q[s-1];
      assign d_in[s]   = d_q[s-1];
      assign sb_in[s]  = sb_q[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign rem_sh  = {rem_in[s], n_in[s][QuoW-1]};
    assign ge      = rem_sh >= {1'b0, d_in[s]};
    assign rem_sub = rem_sh - {1'b0, d_in[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[s] <= ovf_in[s];
      rem_q[s] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      n_q[s]   <= n_in[s] << 1;
      q_q[s]   <= {q_in[s][QuoW-2:0], ge};
      d_q[s]   <= d_in[s];
      sb_q[s]  <= sb_in[s];
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = q_q[QuoW-1];
  assign ovf_o   = ovf_q[QuoW-1];
  assign sb_o    = sb_q[QuoW-1];

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, top level: front end, square root, three dividers.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// Takes one 3x3 rotation block per cycle on start_i (busy_o is always low) and
// returns the quaternion on result_o with a one-cycle done_o strobe. An item
// passes the input register, front-end stages B and C, the square root stages,
// the prep register, the divider entry stage and quotient stages, and the
// output register. The square root and the dividers are fully pipelined, one
// stage per result bit (plus the divider entry stage), so the block sustains
// one item per cycle with results in input order. The receiver cannot hold
// results off. Write near_zero_tolerance only while no item is in flight; it
// resets to 7.
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rmq_pkg::item_t    item_i,
  output logic              done_o,
  output rmq_pkg::result_t  result_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int unsigned FieldW = rmq_pkg::FieldW;
  localparam int unsigned SqInW  = rmq_pkg::RadW + FRAC_BITS;
  localparam int unsigned RootW  = (SqInW + 1) / 2;
  localparam int unsigned DenW   = RootW + 1;
  localparam int unsigned DivNW  = rmq_pkg::NumW + FRAC_BITS + 1;
  localparam int unsigned MainW  = (RootW > FieldW) ? RootW : FieldW;
  localparam int unsigned SbW    = $bits(rmq_pkg::lane_sb_t);
  localparam int unsigned Lat    = 3 + RootW + 1 + 1 + rmq_pkg::QuoW + 1;
  localparam logic signed [FieldW-1:0] OneSat =
    (FRAC_BITS > 22) ? rmq_pkg::SatMax : FieldW'(64'd1 << FRAC_BITS);

  // Tolerance register
  logic [15:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd7;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Input register
  logic           va_q;
  rmq_pkg::item_t ma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= item_i;
  end

  assign busy_o = 1'b0;

  // Front end
  logic                      fr_valid;
  logic [rmq_pkg::RadW-1:0]  fr_rad;
  rmq_pkg::ctl_t             fr_ctl;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .item_i  (ma_q),
    .tol_i   (tol_q),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .ctl_o   (fr_ctl)
  );

  // Square root of the radicand scaled by 2^FRAC_BITS
  logic                       sq_valid;
  logic [RootW-1:0]           sq_root;
  logic [$bits(rmq_pkg::ctl_t)-1:0] sq_sb;
  rmq_pkg::ctl_t              sq_ctl;

  rmq_sqrt #(
    .IN_W (SqInW),
    .SB_W ($bits(rmq_pkg::ctl_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .rad_i   ({fr_rad, {FRAC_BITS{1'b0}}}),
    .sb_i    (fr_ctl),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  assign sq_ctl = rmq_pkg::ctl_t'(sq_sb);

  // Prep: main component, divisor 2r, dividends |d| * 2^FRAC_BITS + r
  logic [RootW:0]             main_sum;
  logic [MainW-1:0]           main_ext;
  rmq_pkg::lane_sb_t          sb0_d;
  logic                       pv_q;
  logic [DenW-1:0]            den_q;
  logic [DivNW-1:0]           num0_q;
  logic [DivNW-1:0]           num1_q;
  logic [DivNW-1:0]           num2_q;
  logic                       neg1_q;
  logic                       neg2_q;
  rmq_pkg::lane_sb_t          sb0_q;

  function automatic logic [DivNW-1:0] dividend(input logic signed [rmq_pkg::NumW-1:0] d,
                                                input logic [RootW-1:0] r);
    logic [DivNW-1:0] v;
    v = DivNW'({rmq_pkg::mag25(d), {FRAC_BITS{1'b0}}}) + DivNW'(r);
    return v;
  endfunction

  always_comb begin
    main_sum = (RootW+1)'(sq_root) + 1'b1;
    main_ext = MainW'(main_sum[RootW:1]);
    sb0_d.degenerate = sq_ctl.degenerate;
    sb0_d.main_axis  = sq_ctl.main_axis;
    sb0_d.neg        = sq_ctl.num0[rmq_pkg::NumW-1];
    if (main_ext > MainW'(rmq_pkg::SatMax)) begin
      sb0_d.main_val = rmq_pkg::SatMax;
    end else begin
      sb0_d.main_val = main_ext[FieldW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= {sq_root, 1'b0};
    num0_q <= dividend(sq_ctl.num0, sq_root);
    num1_q <= dividend(sq_ctl.num1, sq_root);
    num2_q <= dividend(sq_ctl.num2, sq_root);
    neg1_q <= sq_ctl.num1[rmq_pkg::NumW-1];
    neg2_q <= sq_ctl.num2[rmq_pkg::NumW-1];
    sb0_q  <= sb0_d;
  end

  // Three divider lanes, lane 0 carries the item control
  logic                    dv0, dv1, dv2;
  logic [rmq_pkg::QuoW-1:0] quo0, quo1, quo2;
  logic                    ovf0, ovf1, ovf2;
  logic [SbW-1:0]          dsb0;
  logic                    dneg1, dneg2;
  rmq_pkg::lane_sb_t       lane_sb;

  rmq_div #(.NUM_W(DivNW), .DEN_W(DenW), .SB_W(SbW)) u_div0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pv_q), .num_i (num0_q), .den_i (den_q),
    .sb_i (sb0_q), .valid_o (dv0), .quo_o (quo0), .ovf_o (ovf0), .sb_o (dsb0)
  );

  rmq_div #(.NUM_W(DivNW), .DEN_W(DenW), .SB_W(1)) u_div1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pv_q), .num_i (num1_q), .den_i (den_q),
    .sb_i (neg1_q), .valid_o (dv1), .quo_o (quo1), .ovf_o (ovf1), .sb_o (dneg1)
  );

  rmq_div #(.NUM_W(DivNW), .DEN_W(DenW), .SB_W(1)) u_div2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pv_q), .num_i (num2_q), .den_i (den_q),
    .sb_i (neg2_q), .valid_o (dv2), .quo_o (quo2), .ovf_o (ovf2), .sb_o (dneg2)
  );

  assign lane_sb = rmq_pkg::lane_sb_t'(dsb0);

  // Output: sign, saturate and place the lanes by the main axis
  logic signed [FieldW-1:0] l0, l1, l2;
  rmq_pkg::result_t         res_d;
  rmq_pkg::result_t         res_q;
  logic                     done_q;

  always_comb begin
    l0 = rmq_pkg::lane_val(quo0, ovf0, lane_sb.neg);
    l1 = rmq_pkg::lane_val(quo1, ovf1, dneg1);
    l2 = rmq_pkg::lane_val(quo2, ovf2, dneg2);
    res_d.degenerate = lane_sb.degenerate;
    case (lane_sb.main_axis)
      rmq_pkg::AXIS_X: begin
        res_d.quat_x = lane_sb.main_val;
        res_d.quat_y = l1;
        res_d.quat_z = l2;
        res_d.quat_w = l0;
      end
      rmq_pkg::AXIS_Y: begin
        res_d.quat_x = l2;
        res_d.quat_y = lane_sb.main_val;
        res_d.quat_z = l1;
        res_d.quat_w = l0;
      end
      rmq_pkg::AXIS_Z: begin
        res_d.quat_x = l1;
        res_d.quat_y = l2;
        res_d.quat_z = lane_sb.main_val;
        res_d.quat_w = l0;
      end
      default: begin
        res_d.quat_x = l0;
        res_d.quat_y = l1;
        res_d.quat_z = l2;
        res_d.quat_w = lane_sb.main_val;
      end
    endcase
    // near-zero row: drop the arithmetic, return identity
    if (lane_sb.degenerate) begin
      res_d.quat_x = '0;
      res_d.quat_y = '0;
      res_d.quat_z = '0;
      res_d.quat_w = OneSat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // Checks
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv0 == dv1) && (dv0 == dv2))
    else $error("divider lanes out of step");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Lat done_o)
    else $error("result beat missing at fixed latency");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.degenerate) |->
      (result_o.quat_x == '0) && (result_o.quat_y == '0) &&
      (result_o.quat_z == '0) && (result_o.quat_w == OneSat))
    else $error("degenerate beat is not identity");

endmodule
